>>> hw/rtl/btndb_pkg.sv
// ---------------------------------------------------------------------------
// btndb_pkg
// shared types, constants and codes of the button debounce event block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btndb_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int COUNT_BITS  = 16;
  localparam int THR_BITS    = 16;
  localparam int CMP_BITS    = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
  localparam int IDX_BITS    = 2;
  localparam int CODE_BITS   = 3;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [THR_BITS-1:0]   thr_t;
  typedef logic [CMP_BITS-1:0]   cmp_t;
  typedef logic [IDX_BITS-1:0]   btn_idx_t;
  typedef logic [CODE_BITS-1:0]  ev_code_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam ev_code_t EV_NONE    = 3'd0;
  localparam ev_code_t EV_PUSH    = 3'd1;
  localparam ev_code_t EV_SHORT   = 3'd2;
  localparam ev_code_t EV_RELEASE = 3'd3;
  localparam ev_code_t EV_HOLD1   = 3'd4;
  localparam ev_code_t EV_HOLD2   = 3'd5;
  localparam ev_code_t EV_HOLD3   = 3'd6;
  localparam ev_code_t EV_HOLD4   = 3'd7;

  localparam cfg_idx_t REG_ACTIVE_LEVEL = 4'd0;
  localparam cfg_idx_t REG_PUSH_TICKS   = 4'd1;
  localparam cfg_idx_t REG_SHORT_MIN    = 4'd2;
  localparam cfg_idx_t REG_SHORT_MAX    = 4'd3;
  localparam cfg_idx_t REG_HOLD_FIRST   = 4'd4;
  localparam cfg_idx_t REG_HOLD_SECOND  = 4'd5;
  localparam cfg_idx_t REG_HOLD_THIRD   = 4'd6;
  localparam cfg_idx_t REG_HOLD_FOURTH  = 4'd7;

  localparam thr_t RST_PUSH_TICKS  = 16'd50;
  localparam thr_t RST_SHORT_MIN   = 16'd10;
  localparam thr_t RST_SHORT_MAX   = 16'd500;
  localparam thr_t RST_HOLD_FIRST  = 16'd1000;
  localparam thr_t RST_HOLD_SECOND = 16'd2000;
  localparam thr_t RST_HOLD_THIRD  = 16'd3000;
  localparam thr_t RST_HOLD_FOURTH = 16'd10000;

  typedef struct packed {
    logic active_level;
    thr_t push_ticks;
    thr_t short_min;
    thr_t short_max;
    thr_t hold_first;
    thr_t hold_second;
    thr_t hold_third;
    thr_t hold_fourth;
  } cfg_t;

endpackage

>>> hw/rtl/button_debounce_press_hold_events.sv
// ---------------------------------------------------------------------------
// button_debounce_press_hold_events
// debounces tick samples of several buttons and reports push, short press,
// release and hold level events, one result per sample
// ---------------------------------------------------------------------------
//  channel   | signals                                   | moves
//  s_axis    | s_tvalid s_tready s_tdata[7:0]            | one pin sample per request
//  m_axis    | m_tvalid m_tready m_tdata[7:0]            | one event per request
//  cfg       | cfg_valid cfg_ready cfg_index cfg_data    | one register write per request
//
//  a sample sits in the input register, and its event moves into the output
//  register when the output can advance; one sample per cycle sustained unless stalled
//  the per-button state update sits combinationally between the two registers
//  rst is synchronous and restores register defaults and all button state
//  a stalled output holds both registers; the input keeps taking requests
//  while the input register can move on
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_press_hold_events
  import btndb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // button_index[1:0], pin_level[2]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,   // event_button[1:0], event_code[4:2]
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t     cfg;
  logic     in_valid;
  btn_idx_t in_idx;
  logic     in_pin;
  btn_idx_t out_button;
  ev_code_t out_code;
  ev_code_t code;
  logic     advance;

  btndb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btndb_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .commit (advance),
    .idx    (in_idx),
    .pin    (in_pin),
    .code   (code)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {3'b000, out_code, out_button};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_tready && s_tvalid) begin
      in_idx <= s_tdata[1:0];
      in_pin <= s_tdata[2];
    end
    if (advance) begin
      out_button <= in_idx;
      out_code   <= code;
    end
  end

endmodule

>>> hw/rtl/btndb_cfg.sv
// ---------------------------------------------------------------------------
// btndb_cfg
// configuration register file, written through a valid/ready channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btndb_cfg
  import btndb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level <= 1'b0;
      cfg.push_ticks   <= RST_PUSH_TICKS;
      cfg.short_min    <= RST_SHORT_MIN;
      cfg.short_max    <= RST_SHORT_MAX;
      cfg.hold_first   <= RST_HOLD_FIRST;
      cfg.hold_second  <= RST_HOLD_SECOND;
      cfg.hold_third   <= RST_HOLD_THIRD;
      cfg.hold_fourth  <= RST_HOLD_FOURTH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_LEVEL: cfg.active_level <= cfg_data[0];
        REG_PUSH_TICKS:   cfg.push_ticks   <= thr_t'(cfg_data);
        REG_SHORT_MIN:    cfg.short_min    <= thr_t'(cfg_data);
        REG_SHORT_MAX:    cfg.short_max    <= thr_t'(cfg_data);
        REG_HOLD_FIRST:   cfg.hold_first   <= thr_t'(cfg_data);
        REG_HOLD_SECOND:  cfg.hold_second  <= thr_t'(cfg_data);
        REG_HOLD_THIRD:   cfg.hold_third   <= thr_t'(cfg_data);
        REG_HOLD_FOURTH:  cfg.hold_fourth  <= thr_t'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/btndb_core.sv
// ---------------------------------------------------------------------------
// btndb_core
// per-button debouncer, press counter and event phase machine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btndb_core
  import btndb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     commit,
  input  btn_idx_t idx,
  input  logic     pin,
  output ev_code_t code
);

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_PUSH     = 4'd1,
    PH_RELEASE  = 4'd2,
    PH_HOLDING  = 4'd3,
    PH_HOLD1    = 4'd4,
    PH_HOLDING1 = 4'd5,
    PH_HOLD2    = 4'd6,
    PH_HOLDING2 = 4'd7,
    PH_HOLD3    = 4'd8,
    PH_HOLDING3 = 4'd9,
    PH_HOLD4    = 4'd10,
    PH_HOLDING4 = 4'd11
  } phase_t;

  logic   debounced [NUM_BUTTONS];
  logic   last_smp  [NUM_BUTTONS];
  count_t count     [NUM_BUTTONS];
  phase_t phase     [NUM_BUTTONS];

  logic     in_range;
  logic     db_cur, last_cur, db_next;
  count_t   cnt_cur, cnt_inc, count_next;
  phase_t   ph_cur, ph_eff, phase_next;
  cmp_t     c;
  ev_code_t ev;

  assign in_range = int'(idx) < NUM_BUTTONS;
  assign db_cur   = debounced[idx];
  assign last_cur = last_smp[idx];
  assign cnt_cur  = count[idx];
  assign ph_cur   = phase[idx];

  always_comb begin
    db_next = (db_cur | (last_cur & pin)) & (last_cur | pin);
    if (db_next == cfg.active_level) begin
      cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + count_t'(1);
      ph_eff  = ph_cur;
    end else begin
      cnt_inc = cnt_cur;
      ph_eff  = PH_RELEASE;
    end
    c          = cmp_t'(cnt_inc);
    count_next = cnt_inc;
    phase_next = ph_eff;
    ev         = EV_NONE;
    unique case (ph_eff)
      PH_START:    if (c > cmp_t'(cfg.push_ticks)) phase_next = PH_PUSH;
      PH_PUSH:     begin ev = EV_PUSH;  phase_next = PH_HOLDING;  end
      PH_HOLDING:  if (c > cmp_t'(cfg.hold_first)) phase_next = PH_HOLD1;
      PH_RELEASE: begin
        if (c > cmp_t'(cfg.short_min) && c < cmp_t'(cfg.short_max)) begin
          ev = EV_SHORT;
        end else if (c > cmp_t'(cfg.push_ticks)) begin
          ev = EV_RELEASE;
        end
        count_next = '0;
        phase_next = PH_START;
      end
      PH_HOLD1:    begin ev = EV_HOLD1; phase_next = PH_HOLDING1; end
      PH_HOLDING1: if (c > cmp_t'(cfg.hold_second)) phase_next = PH_HOLD2;
      PH_HOLD2:    begin ev = EV_HOLD2; phase_next = PH_HOLDING2; end
      PH_HOLDING2: if (c > cmp_t'(cfg.hold_third)) phase_next = PH_HOLD3;
      PH_HOLD3:    begin ev = EV_HOLD3; phase_next = PH_HOLDING3; end
      PH_HOLDING3: if (c > cmp_t'(cfg.hold_fourth)) phase_next = PH_HOLD4;
      PH_HOLD4:    begin ev = EV_HOLD4; phase_next = PH_HOLDING4; end
      default: ;
    endcase
  end

  assign code = in_range ? ev : EV_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        debounced[i] <= 1'b0;
        last_smp[i]  <= 1'b0;
        count[i]     <= '0;
        phase[i]     <= PH_START;
      end
    end else if (commit && in_range) begin
      debounced[idx] <= db_next;
      last_smp[idx]  <= pin;
      count[idx]     <= count_next;
      phase[idx]     <= phase_next;
    end
  end

  // release phase never survives a committed sample
  a_no_stored_release: assert property (@(posedge clk) disable iff (rst)
    in_range |-> phase[idx] != PH_RELEASE)
    else $error("release phase left in storage");

  // a short press always clears the counter of its button
  a_short_clears: assert property (@(posedge clk) disable iff (rst)
    commit && in_range && code == EV_SHORT |=> count[$past(idx)] == '0)
    else $error("counter not cleared after short press");

  // push and hold events only come while the button reads pressed
  a_hold_pressed: assert property (@(posedge clk) disable iff (rst)
    commit && in_range && code != EV_NONE && code != EV_SHORT && code != EV_RELEASE
    |-> db_next == cfg.active_level)
    else $error("hold event while released");

endmodule
